[sv/rwsp_pkg.sv]
// Shared types and constants of the RIFF/WAVE stream parser.
// No dependencies; imported by the interfaces and every module.
package rwsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [2:0] ERR_NOT_RIFF  = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd2;
  localparam logic [2:0] ERR_FMT_SHORT = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FMT  = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CT_OTHER = 2'd0,
    CT_FMT   = 2'd1,
    CT_DATA  = 2'd2
  } chunk_type_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] data_length;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [2:0]  error_code;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_beat_t;

  // up to two records per input beat; v1 only ever set together with v0
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

  function automatic rec_t simple_rec(kind_t k, logic [2:0] code);
    rec_t r;
    r            = '0;
    r.kind       = k;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

[sv/rwsp_ifs.sv]
// Valid/ready channel interfaces of the parser: byte input and record output.
// Depends on rwsp_pkg.
interface rwsp_in_if import rwsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, in_byte, start_of_file, input ready);
  modport sink   (input valid, in_byte, start_of_file, output ready);
endinterface

interface rwsp_out_if import rwsp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] data_length;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, kind, data_byte, data_length, channel_count, sample_rate,
                  byte_rate, block_align, bits_per_sample, error_code, last,
                  input ready);
  modport sink   (input valid, kind, data_byte, data_length, channel_count, sample_rate,
                  byte_rate, block_align, bits_per_sample, error_code, last,
                  output ready);
endinterface

[sv/rwsp_core.sv]
// Parser state and per-beat record generation for the RIFF/WAVE parser.
// Depends on rwsp_pkg.
module rwsp_core import rwsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t beat,
  output push_t    push
);

  typedef enum logic [4:0] {
    PH_RIFF  = 5'b00001,
    PH_CHUNK = 5'b00010,
    PH_BODY  = 5'b00100,
    PH_DONE  = 5'b01000,
    PH_ERROR = 5'b10000
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        hdr_cnt, hdr_cnt_next;
  logic [31:0]       word_shift, word_shift_next;
  logic [31:0]       riff_rem, riff_rem_next;
  logic [31:0]       chunk_rem, chunk_rem_next;
  logic [31:0]       chunk_total, chunk_total_next;
  chunk_type_t       chunk_type, chunk_type_next;
  logic [15:0][7:0]  fmt, fmt_next;
  logic [4:0]        fmt_off, fmt_off_next;   // saturates at 16
  logic [31:0]       riff_m8;                 // riff_rem - 8, registered from riff_rem
  logic              riff_lt8;

  // start of file clears everything before the byte is looked at
  phase_t            ph_c;
  logic [3:0]        cnt_c;
  logic [31:0]       ws_c, riff_c, crem_c, ctot_c;
  chunk_type_t       ct_c;
  logic [15:0][7:0]  fmt_c;
  logic [4:0]        off_c;

  logic [31:0]       ws_sh;
  logic [3:0]        cnt_inc;
  logic [32:0]       riff_sub4;
  logic [32:0]       riff_subc;
  logic              do_fail;
  logic [2:0]        fail_code;
  logic              do_finish;
  logic [31:0]       fin_riff;

  always_comb begin
    if (beat.start_of_file) begin
      ph_c   = PH_RIFF;
      cnt_c  = '0;
      ws_c   = '0;
      riff_c = '0;
      crem_c = '0;
      ctot_c = '0;
      ct_c   = CT_OTHER;
      fmt_c  = '0;
      off_c  = '0;
    end else begin
      ph_c   = phase;
      cnt_c  = hdr_cnt;
      ws_c   = word_shift;
      riff_c = riff_rem;
      crem_c = chunk_rem;
      ctot_c = chunk_total;
      ct_c   = chunk_type;
      fmt_c  = fmt;
      off_c  = fmt_off;
    end
  end

  assign ws_sh     = {beat.in_byte, ws_c[31:8]};
  assign cnt_inc   = cnt_c + 4'd1;
  assign riff_sub4 = {1'b0, riff_c} - 33'd4;
  assign riff_subc = {1'b0, riff_m8} - {1'b0, ws_sh};

  always_comb begin
    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    word_shift_next  = word_shift;
    riff_rem_next    = riff_rem;
    chunk_rem_next   = chunk_rem;
    chunk_total_next = chunk_total;
    chunk_type_next  = chunk_type;
    fmt_next         = fmt;
    fmt_off_next     = fmt_off;
    push             = '0;
    do_fail          = 1'b0;
    fail_code        = ERR_NOT_RIFF;
    do_finish        = 1'b0;
    fin_riff         = riff_c;

    if (accept) begin
      phase_next       = ph_c;
      hdr_cnt_next     = cnt_c;
      word_shift_next  = ws_c;
      riff_rem_next    = riff_c;
      chunk_rem_next   = crem_c;
      chunk_total_next = ctot_c;
      chunk_type_next  = ct_c;
      fmt_next         = fmt_c;
      fmt_off_next     = off_c;

      unique case (ph_c)
        PH_RIFF: begin
          word_shift_next = ws_sh;
          hdr_cnt_next    = cnt_inc;
          if (cnt_inc == 4'd4 && ws_sh != TAG_RIFF) begin
            do_fail   = 1'b1;
            fail_code = ERR_NOT_RIFF;
          end
          if (cnt_inc == 4'd8) riff_rem_next = ws_sh;
          if (cnt_inc == 4'd12) begin
            hdr_cnt_next = '0;
            priority if (ws_sh != TAG_WAVE) begin
              do_fail   = 1'b1;
              fail_code = ERR_NOT_WAVE;
            end else if (riff_sub4[32]) begin
              do_fail   = 1'b1;
              fail_code = ERR_OVERRUN;
            end else begin
              riff_rem_next = riff_sub4[31:0];
              do_finish     = 1'b1;
              fin_riff      = riff_sub4[31:0];
            end
          end
        end
        PH_CHUNK: begin
          word_shift_next = ws_sh;
          hdr_cnt_next    = cnt_inc;
          if (cnt_inc == 4'd4) begin
            priority if (ws_sh == TAG_FMT) chunk_type_next = CT_FMT;
            else if (ws_sh == TAG_DATA)    chunk_type_next = CT_DATA;
            else                           chunk_type_next = CT_OTHER;
          end
          if (cnt_inc == 4'd8) begin
            hdr_cnt_next = '0;
            priority if (riff_lt8 || riff_subc[32]) begin
              do_fail   = 1'b1;
              fail_code = ERR_OVERRUN;
            end else if (ct_c == CT_FMT && ws_sh < 32'd16) begin
              do_fail   = 1'b1;
              fail_code = ERR_FMT_SHORT;
            end else begin
              riff_rem_next    = riff_subc[31:0];
              chunk_rem_next   = ws_sh;
              chunk_total_next = ws_sh;
              fmt_next         = '0;
              fmt_off_next     = '0;
              if (ws_sh == 32'd0) begin
                do_finish = 1'b1;
                fin_riff  = riff_subc[31:0];
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          chunk_rem_next = crem_c - 32'd1;
          if (ct_c == CT_FMT && !off_c[4]) begin
            fmt_next[off_c[3:0]] = beat.in_byte;
            fmt_off_next         = off_c + 5'd1;
            if (off_c == 5'd15) begin
              if ({fmt_c[1], fmt_c[0]} != 16'd1) begin
                do_fail   = 1'b1;
                fail_code = ERR_NOT_PCM;
              end else begin
                push.v0                 = 1'b1;
                push.r0.kind            = KIND_FMT;
                push.r0.channel_count   = {fmt_c[3], fmt_c[2]};
                push.r0.sample_rate     = {fmt_c[7], fmt_c[6], fmt_c[5], fmt_c[4]};
                push.r0.byte_rate       = {fmt_c[11], fmt_c[10], fmt_c[9], fmt_c[8]};
                push.r0.block_align     = {fmt_c[13], fmt_c[12]};
                push.r0.bits_per_sample = {beat.in_byte, fmt_c[14]};
              end
            end
          end else if (ct_c == CT_DATA) begin
            push.v0             = 1'b1;
            push.r0.kind        = KIND_DATA;
            push.r0.data_byte   = beat.in_byte;
            push.r0.data_length = ctot_c;
            push.r0.last        = (crem_c == 32'd1);
          end
          if (crem_c == 32'd1 && !do_fail) do_finish = 1'b1;
        end
        PH_DONE, PH_ERROR: begin
        end
        default: begin
        end
      endcase

      if (do_fail) begin
        phase_next = PH_ERROR;
        push.v0    = 1'b1;
        push.r0    = simple_rec(KIND_ERR, fail_code);
      end else if (do_finish) begin
        if (fin_riff == 32'd0) begin
          phase_next = PH_DONE;
          // end record follows any record this beat already produced
          if (push.v0) begin
            push.v1 = 1'b1;
            push.r1 = simple_rec(KIND_END, 3'd0);
          end else begin
            push.v0 = 1'b1;
            push.r0 = simple_rec(KIND_END, 3'd0);
          end
        end else begin
          phase_next   = PH_CHUNK;
          hdr_cnt_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RIFF;
      hdr_cnt     <= '0;
      word_shift  <= '0;
      riff_rem    <= '0;
      chunk_rem   <= '0;
      chunk_total <= '0;
      chunk_type  <= CT_OTHER;
      fmt         <= '0;
      fmt_off     <= '0;
    end else begin
      phase       <= phase_next;
      hdr_cnt     <= hdr_cnt_next;
      word_shift  <= word_shift_next;
      riff_rem    <= riff_rem_next;
      chunk_rem   <= chunk_rem_next;
      chunk_total <= chunk_total_next;
      chunk_type  <= chunk_type_next;
      fmt         <= fmt_next;
      fmt_off     <= fmt_off_next;
    end
  end

  // riff_rem only moves on a start of file or within the RIFF or a chunk header, at least
  // eight beats before the next chunk size check reads these
  always_ff @(posedge clk) begin
    riff_m8  <= riff_rem - 32'd8;
    riff_lt8 <= (riff_rem < 32'd8);
  end

endmodule

[sv/rwsp_out_queue.sv]
// Four-entry record queue between the parser core and the output channel.
// Takes up to two records a cycle, gives one. Depends on rwsp_pkg.
module rwsp_out_queue import rwsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space,
  output logic  valid,
  input  logic  ready,
  output rec_t  head
);

  rec_t       entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] n_push;
  logic       pop;

  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop    = valid && ready;
  assign valid  = (count != 3'd0);
  assign head   = entry[rd_ptr];
  // room for the worst case of two records from the next beat
  assign space  = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.v0) entry[wr_ptr] <= push.r0;
    if (push.v1) entry[wr_ptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, n_push} - {2'b00, pop};
    end
  end

endmodule

[sv/riff_wave_stream_parser_top.sv]
// Channel    Dir  Beat contents
// in_ch      in   one file byte, start_of_file flag
// out_ch     out  one record: data byte, format, end or error
//
// One byte is accepted per cycle; its records enter the output queue at the
// same edge and the first can leave on the next cycle. A byte gives at most
// two records; input stalls only when the four-entry queue has fewer than two
// free entries. Reset is synchronous and clears parser state and the queue.
// Top level of the RIFF/WAVE stream parser: rwsp_core and rwsp_out_queue.
// Depends on rwsp_pkg and rwsp_ifs.
module riff_wave_stream_parser_top import rwsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rwsp_in_if.sink       in_ch,
  rwsp_out_if.source    out_ch
);

  logic     accept;
  in_beat_t beat;
  push_t    push;
  logic     space;
  rec_t     head;

  assign accept             = in_ch.valid && in_ch.ready;
  assign in_ch.ready        = space;
  assign beat.in_byte       = in_ch.in_byte;
  assign beat.start_of_file = in_ch.start_of_file;

  rwsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (beat),
    .push   (push)
  );

  rwsp_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .valid (out_ch.valid),
    .ready (out_ch.ready),
    .head  (head)
  );

  assign out_ch.kind            = head.kind;
  assign out_ch.data_byte       = head.data_byte;
  assign out_ch.data_length     = head.data_length;
  assign out_ch.channel_count   = head.channel_count;
  assign out_ch.sample_rate     = head.sample_rate;
  assign out_ch.byte_rate       = head.byte_rate;
  assign out_ch.block_align     = head.block_align;
  assign out_ch.bits_per_sample = head.bits_per_sample;
  assign out_ch.error_code      = head.error_code;
  assign out_ch.last            = head.last;

`ifndef NO_ASSERTIONS
  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0 && push.r1.kind == KIND_END)
    else $error("second record of a beat is not an end record");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    push.v0 && push.r0.kind == KIND_ERR |-> !push.v1)
    else $error("error record followed by another record");

  a_push_needs_beat: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> accept)
    else $error("record produced without an input beat");

  a_end_err_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind == KIND_END || out_ch.kind == KIND_ERR) |-> out_ch.last)
    else $error("end or error record without last");
`endif

endmodule

[tb/sv/rwsp_record_checker.sv]
// Scoreboard for the RIFF/WAVE stream parser: follows the byte stream, predicts
// the records it should give and compares them with the records leaving the block.
// Depends on rwsp_pkg and rwsp_ifs.
module rwsp_record_checker import rwsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  rwsp_in_if   in_ch,
  rwsp_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_RIFF,
    ST_CHUNK,
    ST_BODY,
    ST_DONE,
    ST_ERROR
  } stage_t;

  stage_t      stage;
  logic [3:0]  hdr_count;
  logic [31:0] shift_word;
  logic [31:0] riff_left;
  logic [31:0] chunk_left;
  logic [31:0] chunk_size;
  chunk_type_t chunk_kind;
  logic [63:0] fmt_lo;
  logic [63:0] fmt_hi;

  rec_t due_records[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_parser();
    stage      = ST_RIFF;
    hdr_count  = '0;
    shift_word = '0;
    riff_left  = '0;
    chunk_left = '0;
    chunk_size = '0;
    chunk_kind = CT_OTHER;
    fmt_lo     = '0;
    fmt_hi     = '0;
  endtask

  task automatic raise_error(input logic [2:0] code);
    rec_t r;
    r            = '0;
    r.kind       = KIND_ERR;
    r.error_code = code;
    r.last       = 1'b1;
    stage        = ST_ERROR;
    due_records.push_back(r);
  endtask

  // end of the RIFF header, a chunk body or an empty chunk: either the RIFF is used up or a new header follows
  task automatic close_chunk();
    rec_t r;
    if (riff_left == 0) begin
      r      = '0;
      r.kind = KIND_END;
      r.last = 1'b1;
      stage  = ST_DONE;
      due_records.push_back(r);
    end else begin
      stage     = ST_CHUNK;
      hdr_count = '0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sof);
    logic [31:0] off;
    rec_t        r;
    if (sof) clear_parser();
    case (stage)
      ST_RIFF: begin
        shift_word = {b, shift_word[31:8]};
        hdr_count  = hdr_count + 4'd1;
        if (hdr_count == 4'd4 && shift_word != TAG_RIFF) begin
          raise_error(ERR_NOT_RIFF);
        end else if (hdr_count == 4'd8) begin
          riff_left = shift_word;
        end else if (hdr_count == 4'd12) begin
          hdr_count = '0;
          if (shift_word != TAG_WAVE) raise_error(ERR_NOT_WAVE);
          else if (riff_left < 4) raise_error(ERR_OVERRUN);
          else begin
            riff_left = riff_left - 32'd4;
            close_chunk();
          end
        end
      end
      ST_CHUNK: begin
        shift_word = {b, shift_word[31:8]};
        hdr_count  = hdr_count + 4'd1;
        if (hdr_count == 4'd4) begin
          if (shift_word == TAG_FMT) chunk_kind = CT_FMT;
          else if (shift_word == TAG_DATA) chunk_kind = CT_DATA;
          else chunk_kind = CT_OTHER;
        end
        if (hdr_count == 4'd8) begin
          hdr_count = '0;
          if (riff_left < 8) begin
            raise_error(ERR_OVERRUN);
          end else begin
            riff_left = riff_left - 32'd8;
            // overrun wins over a short fmt
            if (shift_word > riff_left) raise_error(ERR_OVERRUN);
            else if (chunk_kind == CT_FMT && shift_word < 16) raise_error(ERR_FMT_SHORT);
            else begin
              riff_left  = riff_left - shift_word;
              chunk_left = shift_word;
              chunk_size = shift_word;
              fmt_lo     = '0;
              fmt_hi     = '0;
              if (shift_word == 0) close_chunk();
              else stage = ST_BODY;
            end
          end
        end
      end
      ST_BODY: begin
        off        = chunk_size - chunk_left;
        chunk_left = chunk_left - 32'd1;
        if (chunk_kind == CT_FMT && off < 16) begin
          if (off < 8) fmt_lo[off[2:0]*8 +: 8] = b;
          else fmt_hi[off[2:0]*8 +: 8] = b;
          if (off == 15) begin
            if (fmt_lo[15:0] != 16'd1) begin
              raise_error(ERR_NOT_PCM);
              return;
            end
            r                 = '0;
            r.kind            = KIND_FMT;
            r.channel_count   = fmt_lo[31:16];
            r.sample_rate     = fmt_lo[63:32];
            r.byte_rate       = fmt_hi[31:0];
            r.block_align     = fmt_hi[47:32];
            r.bits_per_sample = fmt_hi[63:48];
            due_records.push_back(r);
          end
        end else if (chunk_kind == CT_DATA) begin
          r             = '0;
          r.kind        = KIND_DATA;
          r.data_byte   = b;
          r.data_length = chunk_size;
          r.last        = (chunk_left == 0);
          due_records.push_back(r);
        end
        if (chunk_left == 0) close_chunk();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_record();
    rec_t e;
    if (due_records.size() == 0) begin
      $display("%0t: unexpected record, expected none, actual kind %0d byte %0h code %0d",
               $time, out_ch.kind, out_ch.data_byte, out_ch.error_code);
      fail_count++;
    end else begin
      e = due_records.pop_front();
      check_field("kind", e.kind, out_ch.kind);
      check_field("data_byte", e.data_byte, out_ch.data_byte);
      check_field("data_length", e.data_length, out_ch.data_length);
      check_field("channel_count", e.channel_count, out_ch.channel_count);
      check_field("sample_rate", e.sample_rate, out_ch.sample_rate);
      check_field("byte_rate", e.byte_rate, out_ch.byte_rate);
      check_field("block_align", e.block_align, out_ch.block_align);
      check_field("bits_per_sample", e.bits_per_sample, out_ch.bits_per_sample);
      check_field("error_code", e.error_code, out_ch.error_code);
      check_field("last", e.last, out_ch.last);
    end
  endtask

  // a byte's records can only leave on a later cycle, so input goes first
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      due_records.delete();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        parse_byte(in_ch.in_byte, in_ch.start_of_file);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        compare_record();
    end
    pending <= due_records.size();
  end

endmodule

[tb/sv/riff_wave_stream_parser_top_test.sv]
// Testbench top of the RIFF/WAVE stream parser: builds WAVE files, good and broken,
// feeds them byte by byte with random idling and gives the verdict.
// Depends on rwsp_pkg, rwsp_ifs, the parser RTL and rwsp_record_checker.
module riff_wave_stream_parser_top_test import rwsp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_BEATS = 220;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   beats_sent  = 0;
  bit   holding     = 1'b0;
  int   idle_set[4]  = '{0, 52, 0, 9};
  int   stall_set[4] = '{0, 0, 52, 9};
  event hold_off_go;

  logic [7:0] fbytes[$];

  rwsp_in_if  in_ch();
  rwsp_out_if out_ch();

  riff_wave_stream_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rwsp_record_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holding) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_off_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) fbytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_half(input logic [15:0] h);
    fbytes.push_back(h[7:0]);
    fbytes.push_back(h[15:8]);
  endfunction

  function automatic void set_riff_size(input logic [31:0] w);
    for (int i = 0; i < 4; i++) fbytes[4 + i] = w[8*i +: 8];
  endfunction

  function automatic void put_fmt(input logic [31:0] size, input logic [15:0] tag, chans,
                                  input logic [31:0] rate, brate,
                                  input logic [15:0] align, bits);
    put_word(TAG_FMT);
    put_word(size);
    if (size >= 16) begin
      put_half(tag);
      put_half(chans);
      put_word(rate);
      put_word(brate);
      put_half(align);
      put_half(bits);
      for (int i = 16; i < size; i++) fbytes.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < size; i++) fbytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void put_data(input int len);
    put_word(TAG_DATA);
    put_word(len);
    for (int i = 0; i < len; i++) fbytes.push_back(8'($urandom));
  endfunction

  function automatic void put_random_fmt();
    int          pick;
    logic [31:0] size;
    logic [15:0] tag;
    pick = $urandom_range(99);
    if (pick < 5) size = $urandom_range(15, 0);
    else if (pick < 80) size = 16;
    else size = 16 + $urandom_range(4, 1);
    tag = ($urandom_range(9) == 0) ? 16'($urandom) : 16'd1;
    put_fmt(size, tag, 16'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
  endfunction

  function automatic void build_wave(input int max_len);
    int n_chunks;
    int pick;
    int other_len;
    n_chunks = $urandom_range(4, 1);
    fbytes.delete();
    put_word(TAG_RIFF);
    put_word('0);
    put_word(TAG_WAVE);
    for (int k = 0; k < n_chunks; k++) begin
      pick = $urandom_range(99);
      if ((k == 0 && pick < 85) || pick < 25) begin
        put_random_fmt();
      end else if (pick < 80) begin
        put_data($urandom_range(max_len, 0));
      end else begin
        other_len = $urandom_range(6, 0);
        put_word($urandom);
        put_word(other_len);
        for (int i = 0; i < other_len; i++) fbytes.push_back(8'($urandom));
      end
    end
    set_riff_size(fbytes.size() - 8);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.start_of_file <= sof;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_file(input bit restarts);
    for (int i = 0; i < fbytes.size(); i++)
      send_beat(fbytes[i], i == 0 || (restarts && $urandom_range(299) == 0));
    fbytes.delete();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_file(input int max_len);
    int          pick;
    int          cut;
    logic [31:0] size_w;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise, sometimes behind a proper tag so it gets past the first check
      fbytes.delete();
      if ($urandom_range(1)) put_word(TAG_RIFF);
      repeat ($urandom_range(24, 4)) fbytes.push_back(8'($urandom));
    end else begin
      build_wave(max_len);
      if (pick < 16) begin
        fbytes[$urandom_range(fbytes.size() - 1, 0)] = 8'($urandom);
      end else if (pick < 22) begin
        cut = $urandom_range(fbytes.size() - 1, 1);
        while (fbytes.size() > cut) void'(fbytes.pop_back());
      end else if (pick < 28) begin
        size_w = {fbytes[7], fbytes[6], fbytes[5], fbytes[4]};
        set_riff_size(size_w + $urandom_range(8, 0) - 4);
      end
    end
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1)) fbytes.push_back(8'($urandom));
    send_file(1'b1);
  endtask

  task automatic run_directed();
    // tag that is not RIFF
    put_word(32'h5846_4952);
    send_file(1'b0);
    // tag that is not WAVE
    put_word(TAG_RIFF); put_word(32'd100); put_word(32'h4556_4158);
    send_file(1'b0);
    // RIFF size too small for the WAVE tag
    put_word(TAG_RIFF); put_word(32'd3); put_word(TAG_WAVE);
    send_file(1'b0);
    // empty body, then a byte after the end
    put_word(TAG_RIFF); put_word(32'd4); put_word(TAG_WAVE);
    fbytes.push_back(8'hFF);
    send_file(1'b0);
    // no room left for a chunk header
    put_word(TAG_RIFF); put_word(32'd10); put_word(TAG_WAVE);
    put_word(TAG_DATA); put_word('0);
    send_file(1'b0);
    // chunk beyond the rest of the RIFF, sizes at their maximum
    put_word(TAG_RIFF); put_word('1); put_word(TAG_WAVE);
    put_word(TAG_DATA); put_word('1);
    send_file(1'b0);
    // fmt shorter than 16 bytes
    put_word(TAG_RIFF); put_word(32'd27); put_word(TAG_WAVE);
    put_fmt(15, '0, '0, '0, '0, '0, '0);
    send_file(1'b0);
    // non-PCM format; the bytes after it fall on the latched error
    put_word(TAG_RIFF); put_word(32'd28); put_word(TAG_WAVE);
    put_fmt(16, 16'h0003, 16'd2, 32'd48000, 32'd384000, 16'd8, 16'd32);
    put_word(TAG_RIFF);
    send_file(1'b0);
    // all-ones fmt with a tail, empty chunk, then a data chunk that closes the RIFF
    put_word(TAG_RIFF); put_word(32'd49); put_word(TAG_WAVE);
    put_fmt(18, 16'h0001, '1, '1, '1, '1, '1);
    put_word(32'h5453_494c); put_word('0);
    put_word(TAG_DATA); put_word(32'd3);
    fbytes.push_back(8'h00); fbytes.push_back(8'hFF); fbytes.push_back(8'h5A);
    send_file(1'b0);
    // two fmt chunks, the second closing the RIFF
    put_word(TAG_RIFF); put_word(32'd52); put_word(TAG_WAVE);
    put_fmt(16, 16'h0001, '0, '0, '0, '0, '0);
    put_fmt(16, 16'h0001, 16'd1, 32'd44100, 32'd88200, 16'd2, 16'd8);
    send_file(1'b0);
    // restart two bytes into a data chunk
    put_word(TAG_RIFF); put_word(32'd46); put_word(TAG_WAVE);
    put_fmt(16, 16'h0001, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
    put_data(10);
    while (fbytes.size() > 46) void'(fbytes.pop_back());
    send_file(1'b0);
  endtask

  initial begin
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.start_of_file <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct   = idle_set[p];
      stall_pct <= stall_set[p];
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) random_file(24);
      wait_drained();
    end

    // long data chunk against a stalled receiver: queue fills, input backs up
    idle_pct   = 0;
    stall_pct <= 0;
    fbytes.delete();
    put_word(TAG_RIFF); put_word(32'd116); put_word(TAG_WAVE);
    put_fmt(16, 16'h0001, 16'd2, 32'd48000, 32'd192000, 16'd4, 16'd16);
    put_data(80);
    -> hold_off_go;
    send_file(1'b0);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
